// ===== hw/rtl/urelay_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urelay_pkg
// shared types and command codes for the serial-to-spi motion command relay
// ----------------------------------------------------------------------------
package urelay_pkg;

  // host and slave command bytes
  localparam logic [7:0] CmdStart   = 8'd13;
  localparam logic [7:0] CmdLoad    = 8'd17;
  localparam logic [7:0] CmdSuccess = 8'd19;
  localparam logic [7:0] CmdFailure = 8'd23;
  localparam logic [7:0] CmdStop    = 8'd29;

  // direction words sent to the slave
  localparam logic [7:0] DirForward  = 8'd5;
  localparam logic [7:0] DirBackward = 8'd7;

  // move codes
  localparam logic [7:0] MoveXFwd = 8'h01;
  localparam logic [7:0] MoveXBwd = 8'h03;
  localparam logic [7:0] MoveYFwd = 8'h04;
  localparam logic [7:0] MoveYBwd = 8'h0C;
  localparam logic [7:0] MoveZFwd = 8'h10;
  localparam logic [7:0] MoveZBwd = 8'h30;

  // number of bytes stored after load, and data words sent to the slave
  localparam logic [2:0] LoadBytes = 3'd5;

  // event kinds
  localparam logic ActHostByte = 1'b0;
  localparam logic ActSpiDone  = 1'b1;

  // axis select codes
  localparam logic [1:0] AxisNone = 2'd0;
  localparam logic [1:0] AxisX    = 2'd1;
  localparam logic [1:0] AxisY    = 2'd2;
  localparam logic [1:0] AxisZ    = 2'd3;

  // one result beat
  typedef struct packed {
    logic       spi_send;
    logic [7:0] spi_byte;
    logic       host_send;
    logic [7:0] host_byte;
    logic [1:0] axis_select;
    logic       led_pulse;
  } res_t;

endpackage

// ===== hw/rtl/uart_to_spi_motion_command_relay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_to_spi_motion_command_relay
// bridges host serial command bytes to motor-slave spi transfers
// ----------------------------------------------------------------------------
// Each input beat is one event: a host byte received (action 0) or an spi
// transfer complete carrying the byte the slave shifted back (action 1).
// Every input beat yields exactly one result beat. The block takes one beat
// per cycle while the output side is not stalled; a beat sits in the input
// register, is decoded against the relay state in a single pass, and lands in
// the result register. Under back-pressure the result register holds, and the
// input register holds once it has a beat; the input side keeps accepting
// whenever the result register frees up in the same cycle. No configuration,
// no memories, no clearing pass after reset.
// ----------------------------------------------------------------------------
module uart_to_spi_motion_command_relay (
  input  logic       clk_i,
  input  logic       rst_ni,
  // event beats
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] byte_in_i,
  // result beats
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       spi_send_o,
  output logic [7:0] spi_byte_o,
  output logic       host_send_o,
  output logic [7:0] host_byte_o,
  output logic [1:0] axis_select_o,
  output logic       led_pulse_o
);
  import urelay_pkg::*;

  // input register
  logic       in_valid_q;
  logic       action_q;
  logic [7:0] byte_q;

  // result register
  logic       out_valid_q;
  res_t       res_q;
  res_t       res_d;

  // the held event moves on when the result register is free or draining
  logic       advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload only loads on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      byte_q   <= byte_in_i;
    end
  end

  // decode and state update, committed only when the event advances
  urelay_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .action_i  (action_q),
    .byte_in_i (byte_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign spi_send_o    = res_q.spi_send;
  assign spi_byte_o    = res_q.spi_byte;
  assign host_send_o   = res_q.host_send;
  assign host_byte_o   = res_q.host_byte;
  assign axis_select_o = res_q.axis_select;
  assign led_pulse_o   = res_q.led_pulse;

endmodule

// ===== hw/rtl/urelay_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urelay_core
// relay state and single-pass event decode, one event per enabled cycle
// ----------------------------------------------------------------------------
module urelay_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic               action_i,
  input  logic [7:0]         byte_in_i,
  output urelay_pkg::res_t   res_o
);
  import urelay_pkg::*;

  logic       loading_q, loading_d;
  logic [2:0] load_count_q, load_count_d;
  logic       move_active_q, move_active_d;
  logic       header_pending_q, header_pending_d;
  logic [2:0] send_count_q, send_count_d;
  logic       start_pending_q, start_pending_d;
  logic       stop_pending_q, stop_pending_d;
  logic [7:0] move_code_q, move_code_d;
  logic [7:0] rate_word_q, rate_word_d;
  logic [7:0] motor_low_a_q, motor_low_a_d;
  logic [7:0] motor_low_b_q, motor_low_b_d;
  logic [7:0] motor_high_word_q, motor_high_word_d;
  logic [7:0] move_direction_q, move_direction_d;
  logic [1:0] active_axis_q, active_axis_d;

  always_comb begin
    loading_d         = loading_q;
    load_count_d      = load_count_q;
    move_active_d     = move_active_q;
    header_pending_d  = header_pending_q;
    send_count_d      = send_count_q;
    start_pending_d   = start_pending_q;
    stop_pending_d    = stop_pending_q;
    move_code_d       = move_code_q;
    rate_word_d       = rate_word_q;
    motor_low_a_d     = motor_low_a_q;
    motor_low_b_d     = motor_low_b_q;
    motor_high_word_d = motor_high_word_q;
    move_direction_d  = move_direction_q;
    active_axis_d     = active_axis_q;

    res_o = '0;

    if (action_i == ActHostByte) begin
      if (loading_q) begin
        unique case (load_count_q)
          3'd5: begin
            move_code_d  = byte_in_i;
            load_count_d = 3'd4;
          end
          3'd4: begin
            rate_word_d  = byte_in_i;
            load_count_d = 3'd3;
          end
          3'd3: begin
            motor_low_a_d = byte_in_i;
            load_count_d  = 3'd2;
          end
          3'd2: begin
            motor_low_b_d = byte_in_i;
            load_count_d  = 3'd1;
          end
          3'd1: begin
            motor_high_word_d = byte_in_i;
            loading_d         = 1'b0;
            load_count_d      = 3'd0;
            start_pending_d   = 1'b0;
            stop_pending_d    = 1'b0;
            move_active_d     = 1'b1;
            header_pending_d  = 1'b1;
            send_count_d      = LoadBytes;
            active_axis_d     = AxisNone;
            res_o.spi_send    = 1'b1;
          end
          default: begin
            loading_d    = 1'b0;
            load_count_d = 3'd0;
          end
        endcase
      end else if (byte_in_i == CmdStop || byte_in_i == CmdStart) begin
        // abandon any running sequence, queue the command
        move_active_d    = 1'b0;
        header_pending_d = 1'b0;
        send_count_d     = 3'd0;
        active_axis_d    = AxisNone;
        start_pending_d  = (byte_in_i == CmdStart);
        stop_pending_d   = (byte_in_i == CmdStop);
        res_o.spi_send   = 1'b1;
      end else if (byte_in_i == CmdLoad) begin
        loading_d       = 1'b1;
        load_count_d    = LoadBytes;
        res_o.led_pulse = 1'b1;
      end
      res_o.axis_select = active_axis_d;
    end else begin
      res_o.led_pulse   = 1'b1;
      res_o.axis_select = active_axis_q;
      if (move_active_q) begin
        if (header_pending_q) begin
          unique case (move_code_q)
            MoveXFwd: begin
              active_axis_d    = AxisX;
              move_direction_d = DirForward;
            end
            MoveXBwd: begin
              active_axis_d    = AxisX;
              move_direction_d = DirBackward;
            end
            MoveYFwd: begin
              active_axis_d    = AxisY;
              move_direction_d = DirForward;
            end
            MoveYBwd: begin
              active_axis_d    = AxisY;
              move_direction_d = DirBackward;
            end
            MoveZFwd: begin
              active_axis_d    = AxisZ;
              move_direction_d = DirForward;
            end
            MoveZBwd: begin
              active_axis_d    = AxisZ;
              move_direction_d = DirBackward;
            end
            default: ;
          endcase
          header_pending_d  = 1'b0;
          res_o.spi_send    = 1'b1;
          res_o.spi_byte    = CmdLoad;
          res_o.axis_select = active_axis_d;
        end else begin
          unique case (send_count_q)
            3'd5: begin
              res_o.spi_send = 1'b1;
              res_o.spi_byte = move_direction_q;
              send_count_d   = 3'd4;
            end
            3'd4: begin
              res_o.spi_send = 1'b1;
              res_o.spi_byte = rate_word_q;
              send_count_d   = 3'd3;
            end
            3'd3: begin
              res_o.spi_send = 1'b1;
              res_o.spi_byte = motor_low_a_q;
              send_count_d   = 3'd2;
            end
            3'd2: begin
              res_o.spi_send = 1'b1;
              res_o.spi_byte = motor_low_b_q;
              send_count_d   = 3'd1;
            end
            3'd1: begin
              // last word out, axis still shown on this beat
              res_o.spi_send   = 1'b1;
              res_o.spi_byte   = motor_high_word_q;
              res_o.host_send  = 1'b1;
              res_o.host_byte  = (byte_in_i == CmdSuccess) ? CmdSuccess : CmdFailure;
              move_active_d    = 1'b0;
              header_pending_d = 1'b0;
              send_count_d     = 3'd0;
              active_axis_d    = AxisNone;
            end
            default: begin
              move_active_d     = 1'b0;
              header_pending_d  = 1'b0;
              send_count_d      = 3'd0;
              active_axis_d     = AxisNone;
              res_o.axis_select = AxisNone;
            end
          endcase
        end
      end else if (start_pending_q) begin
        start_pending_d = 1'b0;
        res_o.spi_send  = 1'b1;
        res_o.spi_byte  = CmdStart;
      end else if (stop_pending_q) begin
        stop_pending_d = 1'b0;
        res_o.spi_send = 1'b1;
        res_o.spi_byte = CmdStop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q         <= 1'b0;
      load_count_q      <= 3'd0;
      move_active_q     <= 1'b0;
      header_pending_q  <= 1'b0;
      send_count_q      <= 3'd0;
      start_pending_q   <= 1'b0;
      stop_pending_q    <= 1'b0;
      move_code_q       <= 8'd0;
      rate_word_q       <= 8'd0;
      motor_low_a_q     <= 8'd0;
      motor_low_b_q     <= 8'd0;
      motor_high_word_q <= 8'd0;
      move_direction_q  <= 8'd0;
      active_axis_q     <= AxisNone;
    end else if (step_en_i) begin
      loading_q         <= loading_d;
      load_count_q      <= load_count_d;
      move_active_q     <= move_active_d;
      header_pending_q  <= header_pending_d;
      send_count_q      <= send_count_d;
      start_pending_q   <= start_pending_d;
      stop_pending_q    <= stop_pending_d;
      move_code_q       <= move_code_d;
      rate_word_q       <= rate_word_d;
      motor_low_a_q     <= motor_low_a_d;
      motor_low_b_q     <= motor_low_b_d;
      motor_high_word_q <= motor_high_word_d;
      move_direction_q  <= move_direction_d;
      active_axis_q     <= active_axis_d;
    end
  end

  a_loading_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    loading_q |-> load_count_q != 3'd0)
    else $error("loading with empty byte count");

  a_idle_no_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move_active_q |-> (active_axis_q == AxisNone) && !header_pending_q
                       && (send_count_q == 3'd0))
    else $error("sequence state left over while idle");

  a_one_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_pending_q && stop_pending_q))
    else $error("start and stop both pending");

  a_last_word_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (action_i == ActSpiDone) && move_active_q && !header_pending_q
    && (send_count_q == 3'd1) |=> !move_active_q && (active_axis_q == AxisNone))
    else $error("sequence did not end after last word");

  a_reply_with_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.host_send |-> res_o.spi_send && (action_i == ActSpiDone))
    else $error("host reply without last slave word");

endmodule
